// ----- rtl/core/box_bin_downsample_normalize_unit_assert.svh -----
// assertion macros of the box binning downsampler
// expects clk and rst_n in the scope of each use
`ifndef BOX_BIN_DOWNSAMPLE_NORMALIZE_UNIT_ASSERT_SVH
`define BOX_BIN_DOWNSAMPLE_NORMALIZE_UNIT_ASSERT_SVH

// condition must never hold outside reset
`define BBDN_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bbdn assertion failed");

// antecedent implies consequent in the next cycle
`define BBDN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbdn assertion failed");

`endif

// ----- rtl/core/bbdn_pkg.sv -----
// shared types, constants and tables of the box binning downsampler
// no dependencies
package bbdn_pkg;

    localparam int MAX_BIN       = 16;
    localparam int MAX_OUT_WIDTH = 4096;
    localparam int COL_AW        = 12;
    localparam int SUM_W         = 24;
    localparam int RECIP_SHIFT   = 19;
    localparam int RECIP_W       = 20;
    localparam int DVD_W         = 56;
    localparam int DEN_W         = 40;
    localparam int JOBQ_DEPTH    = 2;

    // register indexes
    localparam logic [2:0] CFG_BIN_FACTOR   = 3'd0;
    localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_OUT_WIDTH    = 3'd3;
    localparam logic [2:0] CFG_OUT_HEIGHT   = 3'd4;
    localparam logic [2:0] CFG_IN_DEPTH     = 3'd5;
    localparam logic [2:0] CFG_OUT_DEPTH    = 3'd6;
    localparam logic [2:0] CFG_PASS_SELECT  = 3'd7;

    typedef struct packed {
        logic [4:0]  bin_factor;
        logic [13:0] image_width;
        logic [13:0] image_height;
        logic [12:0] out_width;
        logic [12:0] out_height;
        logic [4:0]  in_depth;
        logic [4:0]  out_depth;
        logic        pass_select;
    } cfg_t;

    typedef struct packed {
        logic [15:0]      in_min;
        logic [15:0]      in_max;
        logic [SUM_W-1:0] sum_min;
        logic [SUM_W-1:0] sum_max;
    } stats_t;

    typedef struct packed {
        logic             avg;
        logic [SUM_W-1:0] sum;
        logic [4:0]       bin;
        logic [4:0]       od;
        logic [4:0]       id;
        logic [11:0]      row;
        logic [11:0]      col;
    } job_t;

    // ceil(2^RECIP_SHIFT / f), exact quotient for 14-bit positions
    function automatic logic [RECIP_W-1:0] recip(input logic [4:0] f);
        logic [RECIP_W-1:0] r;
        case (f)
            5'd1:    r = 20'd524288;
            5'd2:    r = 20'd262144;
            5'd3:    r = 20'd174763;
            5'd4:    r = 20'd131072;
            5'd5:    r = 20'd104858;
            5'd6:    r = 20'd87382;
            5'd7:    r = 20'd74899;
            5'd8:    r = 20'd65536;
            5'd9:    r = 20'd58255;
            5'd10:   r = 20'd52429;
            5'd11:   r = 20'd47663;
            5'd12:   r = 20'd43691;
            5'd13:   r = 20'd40330;
            5'd14:   r = 20'd37450;
            5'd15:   r = 20'd34953;
            default: r = 20'd32768;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/bbdn_ram.sv -----
// generic single-port ram with registered read
// no dependencies
module bbdn_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- rtl/core/bbdn_front.sv -----
// front part: position tracking, block sums in the line store, statistics
// depends on bbdn_pkg and bbdn_ram
module bbdn_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bbdn_pkg::cfg_t        cfg,
    input  logic                  push,
    input  logic [15:0]           pixel,
    output logic                  full,
    input  logic                  q_full,
    output logic                  q_push,
    output bbdn_pkg::job_t        q_job,
    output bbdn_pkg::stats_t      stats
);

    localparam logic [1:0] ST_CLR  = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_CALC = 2'd2;
    localparam logic [1:0] ST_UPD  = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [12:0] clr_reg, clr_next;
    logic [13:0] col_reg, col_next;
    logic [13:0] row_reg, row_next;
    logic [15:0] px_reg;
    logic [13:0] qc_reg, qr_reg;
    logic [4:0]  cm_reg, rm_reg;
    logic        kept_reg, first_reg;
    logic [15:0] imin_reg, imin_next, imax_reg, imax_next;
    logic [bbdn_pkg::SUM_W-1:0] smin_reg, smin_next, smax_reg, smax_next;
    logic        sempty_reg, sempty_next;

    logic [4:0]  f, od, id;
    logic [13:0] w, h;
    logic [12:0] ow;
    logic [bbdn_pkg::RECIP_W-1:0] rc;
    logic [33:0] prod_c, prod_r;
    logic [13:0] cm, rm;
    logic        kept;
    logic        accept;
    logic        ram_we;
    logic [bbdn_pkg::COL_AW-1:0] ram_addr;
    logic [bbdn_pkg::SUM_W-1:0]  ram_wdata, ram_rdata, sum;
    logic        done, fstart, emit, empty_eff;
    logic [15:0] ibase_min, ibase_max;

    // clamped configuration
    always_comb
    begin
        f  = (cfg.bin_factor == 5'd0) ? 5'd1 :
             ((cfg.bin_factor > 5'(bbdn_pkg::MAX_BIN)) ? 5'(bbdn_pkg::MAX_BIN) : cfg.bin_factor);
        w  = (cfg.image_width == 14'd0) ? 14'd1 : cfg.image_width;
        h  = (cfg.image_height == 14'd0) ? 14'd1 : cfg.image_height;
        ow = (cfg.out_width > 13'(bbdn_pkg::MAX_OUT_WIDTH)) ?
             13'(bbdn_pkg::MAX_OUT_WIDTH) : cfg.out_width;
        od = (cfg.out_depth > 5'd16) ? 5'd16 : cfg.out_depth;
        id = (cfg.in_depth == 5'd0) ? 5'd1 : ((cfg.in_depth > 5'd16) ? 5'd16 : cfg.in_depth);
    end

    // block index by reciprocal multiply
    assign rc     = bbdn_pkg::recip(f);
    assign prod_c = 34'(col_reg) * 34'(rc);
    assign prod_r = 34'(row_reg) * 34'(rc);

    // offsets within the block and kept test
    assign cm   = col_reg - 14'(qc_reg * f);
    assign rm   = row_reg - 14'(qr_reg * f);
    assign kept = (qc_reg < {1'b0, ow}) && (qr_reg < {1'b0, cfg.out_height});

    assign accept = push && !full;
    assign full   = (state_reg != ST_IDLE) || q_full;

    // block sum and completion
    assign sum  = first_reg ? {8'd0, px_reg} : (ram_rdata + {8'd0, px_reg});
    assign done = kept_reg &&
                  ((cm_reg == f - 5'd1) || ({1'b0, col_reg} + 15'd1 >= {1'b0, w})) &&
                  ((rm_reg == f - 5'd1) || ({1'b0, row_reg} + 15'd1 >= {1'b0, h}));
    assign emit = done && ((od == 5'd0) || cfg.pass_select);

    // line store port
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = qc_reg[bbdn_pkg::COL_AW-1:0];
        ram_wdata = sum;
        if (state_reg == ST_CLR)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_reg[bbdn_pkg::COL_AW-1:0];
            ram_wdata = '0;
        end
        else if (state_reg == ST_UPD)
        begin
            ram_we = kept_reg;
        end
    end

    bbdn_ram #(
        .WIDTH (bbdn_pkg::SUM_W),
        .DEPTH (bbdn_pkg::MAX_OUT_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // statistics update
    always_comb
    begin
        fstart    = !cfg.pass_select && (col_reg == 14'd0) && (row_reg == 14'd0);
        ibase_min = fstart ? px_reg : imin_reg;
        ibase_max = fstart ? px_reg : imax_reg;
        empty_eff = fstart ? 1'b1 : sempty_reg;
        imin_next = ibase_min;
        imax_next = ibase_max;
        if (kept_reg && !cfg.pass_select)
        begin
            if (px_reg < ibase_min) imin_next = px_reg;
            if (px_reg > ibase_max) imax_next = px_reg;
        end
        smin_next   = smin_reg;
        smax_next   = smax_reg;
        sempty_next = empty_eff;
        if (done && !cfg.pass_select)
        begin
            sempty_next = 1'b0;
            if (empty_eff)
            begin
                smin_next = sum;
                smax_next = sum;
            end
            else
            begin
                if (sum < smin_reg) smin_next = sum;
                if (sum > smax_reg) smax_next = sum;
            end
        end
    end

    // sequencer and position advance
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        case (state_reg)
            ST_CLR:
            begin
                clr_next = clr_reg + 13'd1;
                if (clr_reg == 13'(bbdn_pkg::MAX_OUT_WIDTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept) state_next = ST_CALC;
            end
            ST_CALC:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                state_next = ST_IDLE;
                if ({1'b0, col_reg} + 15'd1 >= {1'b0, w})
                begin
                    col_next = 14'd0;
                    row_next = ({1'b0, row_reg} + 15'd1 >= {1'b0, h}) ? 14'd0 : row_reg + 14'd1;
                end
                else
                begin
                    col_next = col_reg + 14'd1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLR;
            clr_reg    <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            imin_reg   <= '0;
            imax_reg   <= '0;
            smin_reg   <= '0;
            smax_reg   <= '0;
            sempty_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            if (state_reg == ST_UPD)
            begin
                imin_reg   <= imin_next;
                imax_reg   <= imax_next;
                smin_reg   <= smin_next;
                smax_reg   <= smax_next;
                sempty_reg <= sempty_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= pixel;
            qc_reg <= prod_c[bbdn_pkg::RECIP_SHIFT +: 14];
            qr_reg <= prod_r[bbdn_pkg::RECIP_SHIFT +: 14];
        end
        if (state_reg == ST_CALC)
        begin
            cm_reg    <= cm[4:0];
            rm_reg    <= rm[4:0];
            kept_reg  <= kept;
            first_reg <= (cm == 14'd0) && (rm == 14'd0);
        end
    end

    // job to the back part
    assign q_push    = (state_reg == ST_UPD) && emit;
    assign q_job.avg = (od == 5'd0);
    assign q_job.sum = sum;
    assign q_job.bin = f;
    assign q_job.od  = od;
    assign q_job.id  = id;
    assign q_job.row = qr_reg[11:0];
    assign q_job.col = qc_reg[11:0];

    assign stats.in_min  = imin_reg;
    assign stats.in_max  = imax_reg;
    assign stats.sum_min = smin_reg;
    assign stats.sum_max = smax_reg;

endmodule

// ----- rtl/core/bbdn_jobq.sv -----
// two-entry job queue between front and back
// depends on bbdn_pkg and the assertion header
`include "box_bin_downsample_normalize_unit_assert.svh"

module bbdn_jobq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  bbdn_pkg::job_t wr_job,
    output logic           q_full,
    input  logic           rd_en,
    output bbdn_pkg::job_t rd_job,
    output logic           q_empty
);

    bbdn_pkg::job_t entry_reg [bbdn_pkg::JOBQ_DEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg, cnt_next;

    assign q_full  = (cnt_reg == 2'(bbdn_pkg::JOBQ_DEPTH));
    assign q_empty = (cnt_reg == 2'd0);
    assign rd_job  = entry_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en) cnt_next = cnt_reg + 2'd1;
        if (!wr_en && rd_en) cnt_next = cnt_reg - 2'd1;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en) wp_reg <= ~wp_reg;
            if (rd_en) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wp_reg] <= wr_job;
        end
    end

    `BBDN_ASSERT_NEVER(a_no_overflow, wr_en && q_full)
    `BBDN_ASSERT_NEVER(a_no_underflow, rd_en && q_empty)
    `BBDN_ASSERT_NEXT(a_fill_up, wr_en && !rd_en, cnt_reg == $past(cnt_reg) + 2'd1)

endmodule

// ----- rtl/core/bbdn_back.sv -----
// back part: average or range mapping through a bit-serial divider
// depends on bbdn_pkg
module bbdn_back (
    input  logic             clk,
    input  logic             rst_n,
    input  bbdn_pkg::stats_t stats,
    input  logic             q_empty,
    input  bbdn_pkg::job_t   q_job,
    output logic             q_pop,
    output logic             empty,
    input  logic             pop,
    output logic [23:0]      out_value,
    output logic [11:0]      out_row,
    output logic [11:0]      out_col,
    output logic             flat_image
);

    localparam logic [1:0] BS_IDLE = 2'd0;
    localparam logic [1:0] BS_PREP = 2'd1;
    localparam logic [1:0] BS_DIV  = 2'd2;
    localparam logic [1:0] BS_OUT  = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [5:0]  cnt_reg;
    bbdn_pkg::job_t job_reg;
    logic [39:0] p_reg;
    logic [bbdn_pkg::DEN_W-1:0] den_reg;
    logic [bbdn_pkg::DVD_W-1:0] dvd_reg;
    logic [bbdn_pkg::DEN_W-1:0] rem_reg;
    logic        flat_reg;
    logic        ov_reg;
    logic [23:0] val_reg;
    logic [11:0] row_reg, col_reg;
    logic        oflat_reg;

    logic [23:0] diff, srange;
    logic [15:0] irange;
    logic [9:0]  fsq;
    logic [bbdn_pkg::DEN_W:0] trial;
    logic        ge;
    logic [23:0] quo_sat;
    logic        load_out;

    // operand preparation
    assign diff   = (q_job.sum > stats.sum_min) ? q_job.sum - stats.sum_min : 24'd0;
    assign irange = stats.in_max - stats.in_min;
    assign srange = stats.sum_max - stats.sum_min;
    assign fsq    = 10'(q_job.bin * q_job.bin);

    // one quotient bit per cycle
    assign trial   = {rem_reg, dvd_reg[bbdn_pkg::DVD_W-1]};
    assign ge      = trial >= {1'b0, den_reg};
    assign quo_sat = (dvd_reg[bbdn_pkg::DVD_W-1:24] != '0) ? 24'hFFFFFF : dvd_reg[23:0];

    assign q_pop    = (state_reg == BS_IDLE) && !q_empty;
    assign load_out = (state_reg == BS_OUT) && !ov_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BS_IDLE: if (!q_empty) state_next = BS_PREP;
            BS_PREP: state_next = (flat_reg && !job_reg.avg) ? BS_OUT : BS_DIV;
            BS_DIV:  if (cnt_reg == 6'd0) state_next = BS_OUT;
            BS_OUT:  if (!ov_reg) state_next = BS_IDLE;
            default: state_next = BS_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BS_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                ov_reg <= 1'b1;
            end
            else if (pop)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            BS_IDLE:
            begin
                job_reg  <= q_job;
                p_reg    <= 40'(diff) * 40'(irange);
                flat_reg <= stats.sum_max <= stats.sum_min;
                den_reg  <= q_job.avg ? 40'(fsq) :
                            (40'(srange) << q_job.id) - 40'(srange);
            end
            BS_PREP:
            begin
                rem_reg <= '0;
                cnt_reg <= 6'(bbdn_pkg::DVD_W - 1);
                if (job_reg.avg)
                begin
                    dvd_reg <= {24'd0, job_reg.sum, 8'd0};
                end
                else if (flat_reg)
                begin
                    dvd_reg <= '0;
                end
                else
                begin
                    dvd_reg <= (56'(p_reg) << job_reg.od) - 56'(p_reg);
                end
            end
            BS_DIV:
            begin
                rem_reg <= ge ? 40'(trial - {1'b0, den_reg}) : trial[bbdn_pkg::DEN_W-1:0];
                dvd_reg <= {dvd_reg[bbdn_pkg::DVD_W-2:0], ge};
                cnt_reg <= cnt_reg - 6'd1;
            end
            default:
            begin
                if (load_out)
                begin
                    val_reg   <= quo_sat;
                    row_reg   <= job_reg.row;
                    col_reg   <= job_reg.col;
                    oflat_reg <= flat_reg && !job_reg.avg;
                end
            end
        endcase
    end

    // result register
    assign empty      = !ov_reg;
    assign out_value  = val_reg;
    assign out_row    = row_reg;
    assign out_col    = col_reg;
    assign flat_image = oflat_reg;

endmodule

// ----- rtl/core/box_bin_downsample_normalize_unit.sv -----
// top level of the box binning downsampler with range normalization
// depends on bbdn_pkg, bbdn_front, bbdn_jobq, bbdn_back
//
//  channel   | handshake        | payload
//  ----------+------------------+---------------------------------------
//  input     | push / full      | pixel
//  result    | empty / pop      | out_value, out_row, out_col, flat_image
//  config    | cfg_we           | cfg_index, cfg_wdata
//
// in the front a pixel passes block index multiply, line store read and sum
// write-back; a result in the back is set by the 56-step serial divider,
// which range mapping skips for a flat image. a two-entry job queue sits
// between them.
// after reset the line store is cleared, all 4096 entries, full held high.
// full also rises while the job queue is full; a waiting result holds.
module box_bin_downsample_normalize_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] pixel,
    output logic        empty,
    input  logic        pop,
    output logic [23:0] out_value,
    output logic [11:0] out_row,
    output logic [11:0] out_col,
    output logic        flat_image,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [13:0] cfg_wdata
);

    bbdn_pkg::cfg_t   cfg_reg;
    bbdn_pkg::stats_t stats;
    bbdn_pkg::job_t   wr_job, rd_job;
    logic             q_full, q_empty, q_push, q_pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bin_factor   <= 5'd2;
            cfg_reg.image_width  <= 14'd4096;
            cfg_reg.image_height <= 14'd4096;
            cfg_reg.out_width    <= 13'd2048;
            cfg_reg.out_height   <= 13'd2048;
            cfg_reg.in_depth     <= 5'd16;
            cfg_reg.out_depth    <= 5'd8;
            cfg_reg.pass_select  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bbdn_pkg::CFG_BIN_FACTOR:   cfg_reg.bin_factor   <= cfg_wdata[4:0];
                bbdn_pkg::CFG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_wdata;
                bbdn_pkg::CFG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_wdata;
                bbdn_pkg::CFG_OUT_WIDTH:    cfg_reg.out_width    <= cfg_wdata[12:0];
                bbdn_pkg::CFG_OUT_HEIGHT:   cfg_reg.out_height   <= cfg_wdata[12:0];
                bbdn_pkg::CFG_IN_DEPTH:     cfg_reg.in_depth     <= cfg_wdata[4:0];
                bbdn_pkg::CFG_OUT_DEPTH:    cfg_reg.out_depth    <= cfg_wdata[4:0];
                bbdn_pkg::CFG_PASS_SELECT:  cfg_reg.pass_select  <= cfg_wdata[0];
                default:                    cfg_reg.pass_select  <= cfg_reg.pass_select;
            endcase
        end
    end

    bbdn_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .push   (push),
        .pixel  (pixel),
        .full   (full),
        .q_full (q_full),
        .q_push (q_push),
        .q_job  (wr_job),
        .stats  (stats)
    );

    bbdn_jobq u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_job  (wr_job),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_job  (rd_job),
        .q_empty (q_empty)
    );

    bbdn_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .stats      (stats),
        .q_empty    (q_empty),
        .q_job      (rd_job),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .out_value  (out_value),
        .out_row    (out_row),
        .out_col    (out_col),
        .flat_image (flat_image)
    );

endmodule
